// ===== rtl/core/page_framebuffer_engine_assert.svh =====
// Assertion macros used by the checker of the page framebuffer engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PAGE_FRAMEBUFFER_ENGINE_ASSERT_SVH
`define PAGE_FRAMEBUFFER_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PFB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pfb_pkg.sv =====
package pfb_pkg;

  // Default screen size.
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  // Page organization: eight vertical pixels per byte.
  localparam int PAGE_ROWS = 8;
  localparam int ROW_MASK  = 7;

  // Request codes; the two unused codes fall to the default arm.
  typedef enum logic [2:0] {
    REQ_DRAW       = 3'd0,
    REQ_READ_PIXEL = 3'd1,
    REQ_FILL       = 3'd2,
    REQ_SCROLL     = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_READ_BYTE  = 3'd5
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_WR,
    ST_RES
  } state_t;

endpackage

// ===== rtl/core/page_framebuffer_engine.sv =====
// Page-organized monochrome framebuffer. A request is taken when start is high and busy is
// low; its single result appears one cycle on out_pixel_value and out_byte_value with
// out_strobe high and must be taken then, since the receiver cannot stall the block. The
// image lives in one RAM of SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes with a registered
// read, and every request is a walk of that RAM's single read and write port: a pixel draw
// or a fill reads and writes back each touched byte, a pixel or byte read reads one byte, a
// scroll reads two source bytes and writes one for every store byte, and a clear writes zero
// to every store byte. Requests that touch no byte (an off-screen pixel, an empty or
// off-screen rectangle, a byte address past the store, a scroll by zero rows, or an unused
// code) give their result straight from the idle state. After reset the block sweeps zeros
// through every store byte (1024 bytes at the default 128 x 64 size) with busy high, and
// gives no result for that sweep.
module page_framebuffer_engine #(
  parameter int SCREEN_WIDTH  = pfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [7:0] in_x_pos,
  input  logic [7:0] in_y_pos,
  input  logic [7:0] in_rect_width,
  input  logic [7:0] in_rect_height,
  input  logic       in_pixel_color,
  input  logic [7:0] in_scroll_rows,
  input  logic [9:0] in_byte_addr,
  output logic       out_strobe,
  output logic       out_pixel_value,
  output logic [7:0] out_byte_value
);
  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = $clog2(PAGE_COUNT + 1);

  localparam logic [8:0]        WIDTH_LIM  = 9'(SCREEN_WIDTH);
  localparam logic [8:0]        HEIGHT_LIM = 9'(SCREEN_HEIGHT);
  localparam logic [PAGE_W:0]   PAGE_LIM   = (PAGE_W + 1)'(PAGE_COUNT);
  localparam logic [PAGE_W-1:0] PAGE_MAX   = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [7:0]        COL_MAX    = 8'(SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ADDR_MAX   = ADDR_W'(STORE_BYTES - 1);

  // Store byte address of a page and column.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [PAGE_W:0] pg,
                                                input logic [7:0] col);
    logic [31:0] lin;
    lin = 32'(pg) * 32'(SCREEN_WIDTH) + 32'(col);
    return lin[ADDR_W-1:0];
  endfunction

  state_t state_r, state_nxt;
  req_t   op_r, op_nxt;
  logic   color_r, color_nxt;
  logic   clr_req_r, clr_req_nxt;

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [PAGE_W-1:0] page_last_r, page_last_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        col_first_r, col_first_nxt;
  logic [7:0]        col_last_r, col_last_nxt;
  logic [7:0]        y_lo_r, y_lo_nxt;
  logic [7:0]        y_end_r, y_end_nxt;
  logic [PAGE_W-1:0] shift_pages_r, shift_pages_nxt;
  logic [2:0]        shift_bits_r, shift_bits_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [ADDR_W-1:0] baddr_r, baddr_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic       out_strobe_r, out_strobe_nxt;
  logic       out_pixel_r, out_pixel_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Request decode helpers.
  logic [8:0]  x_end_sum, y_end_sum, x_end_clip, y_end_clip;
  logic [8:0]  rows_sat;
  logic [31:0] baddr_ext;
  logic        pix_in_screen;

  // Scroll source pages and the fill row mask.
  logic [PAGE_W:0] src_pg_a, src_pg_b;
  logic            src_ok_a, src_ok_b;
  logic [7:0]      fill_mask;
  logic [15:0]     scroll_pair;
  logic [2:0]      bit_sel;

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Clipping and range checks on the request fields.
  always_comb begin
    x_end_sum  = 9'(in_x_pos) + 9'(in_rect_width);
    y_end_sum  = 9'(in_y_pos) + 9'(in_rect_height);
    x_end_clip = (x_end_sum > WIDTH_LIM) ? WIDTH_LIM : x_end_sum;
    y_end_clip = (y_end_sum > HEIGHT_LIM) ? HEIGHT_LIM : y_end_sum;
    rows_sat   = (9'(in_scroll_rows) > HEIGHT_LIM) ? HEIGHT_LIM : 9'(in_scroll_rows);
    baddr_ext  = 32'(in_byte_addr);
    pix_in_screen = (9'(in_x_pos) < WIDTH_LIM) && (9'(in_y_pos) < HEIGHT_LIM);
  end

  // Source pages of a scroll step, zero beyond the last page.
  always_comb begin
    src_pg_a = {1'b0, page_r} + {1'b0, shift_pages_r};
    src_pg_b = src_pg_a + 1'b1;
    src_ok_a = src_pg_a < PAGE_LIM;
    src_ok_b = src_pg_b < PAGE_LIM;
    scroll_pair = {(src_ok_b ? ram_rdata : 8'd0), (src_ok_a ? lo_r : 8'd0)} >> shift_bits_r;
    bit_sel = 3'(y_lo_r & 8'(ROW_MASK));
  end

  // Rows of the current page that fall inside the fill band.
  always_comb begin
    logic [8:0] row;
    for (int b = 0; b < PAGE_ROWS; b++) begin
      row = 9'({page_r, 3'(b)});
      fill_mask[b] = (row >= 9'(y_lo_r)) && (row < 9'(y_end_r));
    end
  end

  // Next state, datapath registers and RAM control.
  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    color_nxt       = color_r;
    clr_req_nxt     = clr_req_r;
    page_nxt        = page_r;
    page_last_nxt   = page_last_r;
    col_nxt         = col_r;
    col_first_nxt   = col_first_r;
    col_last_nxt    = col_last_r;
    y_lo_nxt        = y_lo_r;
    y_end_nxt       = y_end_r;
    shift_pages_nxt = shift_pages_r;
    shift_bits_nxt  = shift_bits_r;
    lo_nxt          = lo_r;
    baddr_nxt       = baddr_r;
    clr_cnt_nxt     = clr_cnt_r;
    out_strobe_nxt  = 1'b0;
    out_pixel_nxt   = 1'b0;
    out_byte_nxt    = 8'd0;
    ram_we          = 1'b0;
    ram_waddr       = addr_of({1'b0, page_r}, col_r);
    ram_wdata       = 8'd0;
    ram_raddr       = addr_of({1'b0, page_r}, col_r);

    unique case (state_r)
      // Zero sweep after reset or for a clear request.
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == ADDR_MAX) begin
          out_strobe_nxt = clr_req_r;
          state_nxt      = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      // Decode a new request on transfer.
      ST_IDLE: begin
        if (start) begin
          color_nxt = in_pixel_color;
          unique case (in_req_type)
            REQ_DRAW: begin
              op_nxt = REQ_FILL;
              if (pix_in_screen) begin
                col_nxt       = in_x_pos;
                col_first_nxt = in_x_pos;
                col_last_nxt  = in_x_pos;
                page_nxt      = PAGE_W'(in_y_pos >> 3);
                page_last_nxt = PAGE_W'(in_y_pos >> 3);
                y_lo_nxt      = in_y_pos;
                y_end_nxt     = in_y_pos + 8'd1;
                state_nxt     = ST_RD_A;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            REQ_READ_PIXEL: begin
              op_nxt = REQ_READ_PIXEL;
              if (pix_in_screen) begin
                col_nxt   = in_x_pos;
                page_nxt  = PAGE_W'(in_y_pos >> 3);
                y_lo_nxt  = in_y_pos;
                state_nxt = ST_RD_A;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            REQ_FILL: begin
              op_nxt = REQ_FILL;
              if ((9'(in_x_pos) < x_end_clip) && (9'(in_y_pos) < y_end_clip)) begin
                col_nxt       = in_x_pos;
                col_first_nxt = in_x_pos;
                col_last_nxt  = 8'(x_end_clip - 9'd1);
                page_nxt      = PAGE_W'(in_y_pos >> 3);
                page_last_nxt = PAGE_W'((y_end_clip - 9'd1) >> 3);
                y_lo_nxt      = in_y_pos;
                y_end_nxt     = 8'(y_end_clip);
                state_nxt     = ST_RD_A;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            REQ_SCROLL: begin
              op_nxt = REQ_SCROLL;
              if (rows_sat != 9'd0) begin
                col_nxt         = 8'd0;
                col_first_nxt   = 8'd0;
                col_last_nxt    = COL_MAX;
                page_nxt        = '0;
                page_last_nxt   = PAGE_MAX;
                shift_pages_nxt = PAGE_W'(rows_sat >> 3);
                shift_bits_nxt  = rows_sat[2:0];
                state_nxt       = ST_RD_A;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            REQ_CLEAR: begin
              op_nxt      = REQ_CLEAR;
              clr_req_nxt = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            REQ_READ_BYTE: begin
              op_nxt = REQ_READ_BYTE;
              if (baddr_ext < 32'(STORE_BYTES)) begin
                baddr_nxt = baddr_ext[ADDR_W-1:0];
                state_nxt = ST_RD_A;
              end else begin
                out_strobe_nxt = 1'b1;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      // First read of a step.
      ST_RD_A: begin
        priority case (op_r)
          REQ_SCROLL: begin
            ram_raddr = addr_of(src_ok_a ? src_pg_a : '0, col_r);
            state_nxt = ST_RD_B;
          end
          REQ_READ_BYTE: begin
            ram_raddr = baddr_r;
            state_nxt = ST_RES;
          end
          REQ_READ_PIXEL: begin
            state_nxt = ST_RES;
          end
          default: begin
            state_nxt = ST_WR;
          end
        endcase
      end

      // Second read of a scroll step: the page below the first source page.
      ST_RD_B: begin
        ram_raddr = addr_of(src_ok_b ? src_pg_b : '0, col_r);
        lo_nxt    = ram_rdata;
        state_nxt = ST_WR;
      end

      // Write back the modified byte and advance over columns, then pages.
      ST_WR: begin
        ram_we = 1'b1;
        if (op_r == REQ_SCROLL) begin
          ram_wdata = scroll_pair[7:0];
        end else if (color_r) begin
          ram_wdata = ram_rdata | fill_mask;
        end else begin
          ram_wdata = ram_rdata & ~fill_mask;
        end
        if (col_r == col_last_r) begin
          if (page_r == page_last_r) begin
            out_strobe_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            page_nxt  = page_r + 1'b1;
            col_nxt   = col_first_r;
            state_nxt = ST_RD_A;
          end
        end else begin
          col_nxt   = col_r + 8'd1;
          state_nxt = ST_RD_A;
        end
      end

      // Read data is back: form the result.
      ST_RES: begin
        out_strobe_nxt = 1'b1;
        if (op_r == REQ_READ_PIXEL) begin
          out_pixel_nxt = ram_rdata[bit_sel];
        end else begin
          out_byte_nxt = ram_rdata;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_req_r    <= 1'b0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
      out_pixel_r  <= 1'b0;
      out_byte_r   <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      clr_req_r    <= clr_req_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_pixel_r  <= out_pixel_nxt;
      out_byte_r   <= out_byte_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    color_r       <= color_nxt;
    page_r        <= page_nxt;
    page_last_r   <= page_last_nxt;
    col_r         <= col_nxt;
    col_first_r   <= col_first_nxt;
    col_last_r    <= col_last_nxt;
    y_lo_r        <= y_lo_nxt;
    y_end_r       <= y_end_nxt;
    shift_pages_r <= shift_pages_nxt;
    shift_bits_r  <= shift_bits_nxt;
    lo_r          <= lo_nxt;
    baddr_r       <= baddr_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_pixel_value = out_pixel_r;
  assign out_byte_value  = out_byte_r;

endmodule

// ===== rtl/core/pfb_ram.sv =====
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data; a read sees writes of earlier edges.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/pfb_checker.sv =====
`include "page_framebuffer_engine_assert.svh"

module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_pixel_value,
  input logic [7:0] out_byte_value
);

  // Result ports stay at zero between results.
  `PFB_ASSERT_IMPL(a_quiet_outputs, !out_strobe, (out_pixel_value == 1'b0) && (out_byte_value == 8'd0), "result ports nonzero without strobe")

  // A result comes from one request, so a pixel and a byte are never both set.
  `PFB_ASSERT_IMPL(a_one_field, out_strobe && out_pixel_value, out_byte_value == 8'd0, "pixel and byte result both set")

  // After a transfer the block is either working or giving the result.
  `PFB_ASSERT_NEXT(a_transfer_progress, start && !busy, busy || out_strobe, "transfer left no trace")

  // No result without a transfer or work in the cycle before.
  `PFB_ASSERT_IMPL(a_result_cause, out_strobe, $past(busy) || $past(start && !busy), "result without a request")

  // The store is swept after reset, so the block is busy right away.
  `PFB_ASSERT_IMPL(a_reset_sweep, !$past(rst_n), busy, "no clearing sweep after reset")

endmodule

bind page_framebuffer_engine pfb_checker u_pfb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_strobe      (out_strobe),
  .out_pixel_value (out_pixel_value),
  .out_byte_value  (out_byte_value)
);
